### hdl/cpfa_pkg.sv
package cpfa_pkg;

    // Managed memory geometry.
    localparam int PAGES      = 32768;
    localparam int PAGE_SHIFT = 12;
    localparam int REF_BITS   = 8;

    // Derived widths.
    localparam int ADDR_W  = 56;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 3;
    localparam int FREE_W  = 16;
    localparam int IDX_W   = $clog2(PAGES);
    localparam int DEPTH_W = $clog2(PAGES + 1);
    // Page walk addresses carry two extra bits so that base plus offset never wraps.
    localparam int P_W     = ADDR_W + 2;

    localparam logic [P_W-1:0] PAGE_BYTES_P = P_W'(1) << PAGE_SHIFT;

    // Configuration register map: one 64-bit register every 8 bytes.
    localparam int REG_COUNT  = 3;
    localparam int CFG_ADDR_W = $clog2(REG_COUNT * 8);
    localparam int CFG_DATA_W = 64;
    localparam int REG_IDX_W  = CFG_ADDR_W - 3;

    localparam logic [REG_IDX_W-1:0] REG_BASE       = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_FIRST_FREE = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_TOP        = REG_IDX_W'(2);

    localparam logic [ADDR_W-1:0] BASE_RST       = ADDR_W'(64'h0000_0000_8000_0000);
    localparam logic [ADDR_W-1:0] FIRST_FREE_RST = ADDR_W'(64'h0000_0000_8000_0000);
    localparam logic [ADDR_W-1:0] TOP_RST        = ADDR_W'(64'h0000_0000_8800_0000);

    // Request commands.
    localparam logic [CMD_W-1:0] CMD_INIT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COW   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SHARE = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE     = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_ADDR    = 3'd2;
    localparam logic [STAT_W-1:0] ST_DOUBLE_FREE = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_MEM      = 3'd4;

    // Configuration values as seen by the allocator core.
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] first_free;
        logic [ADDR_W-1:0] top;
    } t_cfg;

endpackage

### hdl/cpfa_req_if.sv
interface cpfa_req_if import cpfa_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;

    modport source (output valid, output cmd, output addr, input ready);
    modport sink   (input valid, input cmd, input addr, output ready);

endinterface

### hdl/cpfa_rsp_if.sv
interface cpfa_rsp_if import cpfa_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] result_addr;
    logic [STAT_W-1:0] status;
    logic              copy_needed;
    logic              page_released;
    logic [FREE_W-1:0] free_pages;

    modport source (
        output valid, output result_addr, output status, output copy_needed,
        output page_released, output free_pages, input ready
    );
    modport sink (
        input valid, input result_addr, input status, input copy_needed,
        input page_released, input free_pages, output ready
    );

endinterface

### hdl/cpfa_ram.sv
module cpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/cpfa_apb_regs.sv
module cpfa_apb_regs import cpfa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [ADDR_W-1:0]    r_base;
    logic [ADDR_W-1:0]    r_first_free;
    logic [ADDR_W-1:0]    r_top;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= BASE_RST;
            r_first_free <= FIRST_FREE_RST;
            r_top        <= TOP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BASE:       r_base       <= pwdata[ADDR_W-1:0];
                REG_FIRST_FREE: r_first_free <= pwdata[ADDR_W-1:0];
                REG_TOP:        r_top        <= pwdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux; unmapped addresses read as zero.
    always_comb begin
        unique case (reg_idx)
            REG_BASE:       prdata = CFG_DATA_W'(r_base);
            REG_FIRST_FREE: prdata = CFG_DATA_W'(r_first_free);
            REG_TOP:        prdata = CFG_DATA_W'(r_top);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.base       = r_base;
    assign o_cfg.first_free = r_first_free;
    assign o_cfg.top        = r_top;

endmodule

### hdl/cow_page_frame_allocator.sv
// Reference-counted page frame allocator for copy-on-write. Requests (init, alloc, free,
// copy-on-write, share) enter on the request channel and each gives exactly one transfer on
// the response channel, which always reports the depth of the free-page stack. Counts live
// in a single-port-write count memory and free page indices in a stack memory, both with a
// registered read. A request passes through accept, which issues both reads, and execute,
// which writes back; a copy-on-write that hands out a new page adds a second-write state,
// since the count memory needs a second write, and then posts its response in a state of
// its own. Init sweeps every count entry and pushes the qualifying pages one per cycle
// before posting its response. After reset a clearing pass zeroes the count memory while
// the request channel is not ready; configuration writes are taken during it. A finished
// response waits in an output register, so the next request is accepted while it is
// pending; execution holds only if a second response is ready before the first has been
// taken. Configure only while idle.
module cow_page_frame_allocator import cpfa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cpfa_req_if.sink              i_req,
    cpfa_rsp_if.source            o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_COW2 = 3'd3;
    localparam logic [2:0] S_INIT = 3'd4;
    localparam logic [2:0] S_POST = 3'd5;

    t_cfg cfg;

    // Control state.
    logic [2:0]         r_state, n_state;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [IDX_W-1:0]   r_cursor, n_cursor;
    logic [P_W-1:0]     r_init_p, n_init_p;
    logic               r_out_valid;

    // Request and pending-result payload.
    logic [CMD_W-1:0]    r_cmd;
    logic [ADDR_W-1:0]   r_addr;
    logic [IDX_W-1:0]    r_idx;
    logic                r_off_ok;
    logic [P_W-1:0]      r_start;
    logic [IDX_W-1:0]    r_cow_idx;
    logic [REF_BITS-1:0] r_cow_cnt;
    logic [ADDR_W-1:0]   r_pend_addr;
    logic [STAT_W-1:0]   r_pend_status;
    logic                r_pend_copy;
    logic                r_pend_rel;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [STAT_W-1:0]   r_out_status;
    logic                r_out_copy;
    logic                r_out_rel;
    logic [FREE_W-1:0]   r_out_free;

    // Memory ports.
    logic                cnt_we, stk_we, mem_re;
    logic [IDX_W-1:0]    cnt_waddr, cnt_raddr, stk_waddr, stk_raddr;
    logic [REF_BITS-1:0] cnt_wdata, cnt_rdata;
    logic [IDX_W-1:0]    stk_wdata, stk_rdata;

    // Execute-stage results.
    logic [ADDR_W-1:0]   ex_res;
    logic [STAT_W-1:0]   ex_status;
    logic                ex_copy, ex_rel;
    logic                out_load, out_from_ex;

    logic                req_fire, slot_free;
    logic [ADDR_W-1:0]   acc_diff;
    logic [DEPTH_W-1:0]  depth_m1;
    logic                addr_ok, cnt_zero, cnt_le1, cnt_max, stack_empty, stack_full;
    logic [ADDR_W-1:0]   new_page_addr;
    logic [P_W-1:0]      start_p;
    logic                init_qual;

    function automatic logic [FREE_W-1:0] sat_free(input logic [DEPTH_W-1:0] d);
        logic [31:0] w;
        w = 32'(d);
        return (w > 32'((64'd1 << FREE_W) - 1)) ? '1 : w[FREE_W-1:0];
    endfunction

    cpfa_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cpfa_ram #(.WIDTH(REF_BITS), .DEPTH(PAGES)) u_count_mem (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (mem_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    cpfa_ram #(.WIDTH(IDX_W), .DEPTH(PAGES)) u_stack_mem (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (mem_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // Handshake.
    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign slot_free   = !r_out_valid || o_rsp.ready;

    // Accept cycle: look up the count of the addressed page and the top of the stack.
    assign acc_diff  = i_req.addr - cfg.base;
    assign depth_m1  = r_depth - DEPTH_W'(1);
    assign mem_re    = req_fire;
    assign cnt_raddr = acc_diff[PAGE_SHIFT +: IDX_W];
    assign stk_raddr = depth_m1[IDX_W-1:0];

    // Execute-cycle checks on the registered request and the read data.
    assign addr_ok = (r_addr[PAGE_SHIFT-1:0] == '0) && (r_addr >= cfg.first_free)
                  && (r_addr < cfg.top) && (r_addr >= cfg.base) && r_off_ok;
    assign cnt_zero    = (cnt_rdata == '0);
    assign cnt_le1     = (cnt_rdata < REF_BITS'(2));
    assign cnt_max     = (cnt_rdata == '1);
    assign stack_empty = (r_depth == '0);
    assign stack_full  = (r_depth == DEPTH_W'(PAGES));
    assign new_page_addr = cfg.base + (ADDR_W'(stk_rdata) << PAGE_SHIFT);

    // Init walk: first page boundary at or above the first free address.
    assign start_p   = (P_W'(cfg.first_free) + PAGE_BYTES_P - P_W'(1))
                     & ~(PAGE_BYTES_P - P_W'(1));
    assign init_qual = (r_init_p >= r_start) && ((r_init_p + PAGE_BYTES_P) <= P_W'(cfg.top));

    // Sequencer and memory write control.
    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_cursor    = r_cursor;
        n_init_p    = r_init_p;
        cnt_we      = 1'b0;
        cnt_waddr   = r_idx;
        cnt_wdata   = '0;
        stk_we      = 1'b0;
        stk_waddr   = r_depth[IDX_W-1:0];
        stk_wdata   = r_idx;
        ex_res      = '0;
        ex_status   = ST_OK;
        ex_copy     = 1'b0;
        ex_rel      = 1'b0;
        out_load    = 1'b0;
        out_from_ex = 1'b0;
        unique case (r_state)
            S_CLR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_cursor;
                n_cursor  = r_cursor + IDX_W'(1);
                if (r_cursor == IDX_W'(PAGES - 1)) begin
                    n_cursor = '0;
                    n_state  = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_cmd)
                    CMD_ALLOC: begin
                        if (stack_empty) begin
                            ex_status = ST_NO_FREE;
                        end else begin
                            n_depth   = depth_m1;
                            cnt_we    = 1'b1;
                            cnt_waddr = stk_rdata;
                            cnt_wdata = REF_BITS'(1);
                            ex_res    = new_page_addr;
                        end
                    end
                    CMD_FREE: begin
                        if (!addr_ok) begin
                            ex_status = ST_BAD_ADDR;
                        end else if (cnt_zero) begin
                            ex_status = ST_DOUBLE_FREE;
                        end else begin
                            cnt_we    = 1'b1;
                            cnt_wdata = cnt_rdata - REF_BITS'(1);
                            if (cnt_le1 && !stack_full) begin
                                stk_we  = 1'b1;
                                n_depth = r_depth + DEPTH_W'(1);
                                ex_rel  = 1'b1;
                            end
                        end
                    end
                    CMD_COW: begin
                        if (!addr_ok) begin
                            ex_status = ST_BAD_ADDR;
                        end else if (cnt_le1) begin
                            ex_res = r_addr;
                        end else if (stack_empty) begin
                            ex_status = ST_NO_MEM;
                        end else begin
                            // New page gets its count now, the old count drops next cycle.
                            n_depth   = depth_m1;
                            cnt_we    = 1'b1;
                            cnt_waddr = stk_rdata;
                            cnt_wdata = REF_BITS'(1);
                            ex_res    = new_page_addr;
                            ex_copy   = 1'b1;
                        end
                    end
                    CMD_SHARE: begin
                        if (!addr_ok || cnt_zero) begin
                            ex_status = ST_BAD_ADDR;
                        end else begin
                            cnt_we    = !cnt_max;
                            cnt_wdata = cnt_rdata + REF_BITS'(1);
                            ex_res    = r_addr;
                        end
                    end
                    default: ;
                endcase
                if (r_cmd == CMD_INIT) begin
                    n_depth  = '0;
                    n_cursor = '0;
                    n_init_p = P_W'(cfg.base);
                    n_state  = S_INIT;
                end else if (ex_copy) begin
                    n_state = S_COW2;
                end else if (slot_free) begin
                    out_load    = 1'b1;
                    out_from_ex = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_POST;
                end
            end
            S_COW2: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_cow_idx;
                cnt_wdata = r_cow_cnt;
                n_state   = S_POST;
            end
            S_INIT: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_cursor;
                stk_wdata = r_cursor;
                if (init_qual) begin
                    stk_we  = 1'b1;
                    n_depth = r_depth + DEPTH_W'(1);
                end
                n_init_p = r_init_p + PAGE_BYTES_P;
                n_cursor = r_cursor + IDX_W'(1);
                if (r_cursor == IDX_W'(PAGES - 1)) begin
                    n_cursor = '0;
                    n_state  = S_POST;
                end
            end
            S_POST: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_depth     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_depth  <= n_depth;
            r_cursor <= n_cursor;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_init_p <= n_init_p;
        if (req_fire) begin
            r_cmd    <= i_req.cmd;
            r_addr   <= i_req.addr;
            r_idx    <= acc_diff[PAGE_SHIFT +: IDX_W];
            r_off_ok <= (acc_diff[ADDR_W-1:PAGE_SHIFT] < (ADDR_W - PAGE_SHIFT)'(PAGES));
        end
        if (r_state == S_EXEC) begin
            r_start       <= start_p;
            r_cow_idx     <= r_idx;
            r_cow_cnt     <= cnt_rdata - REF_BITS'(1);
            r_pend_addr   <= ex_res;
            r_pend_status <= ex_status;
            r_pend_copy   <= ex_copy;
            r_pend_rel    <= ex_rel;
        end
        if (out_load) begin
            r_out_addr   <= out_from_ex ? ex_res    : r_pend_addr;
            r_out_status <= out_from_ex ? ex_status : r_pend_status;
            r_out_copy   <= out_from_ex ? ex_copy   : r_pend_copy;
            r_out_rel    <= out_from_ex ? ex_rel    : r_pend_rel;
            r_out_free   <= out_from_ex ? sat_free(n_depth) : sat_free(r_depth);
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.result_addr   = r_out_addr;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.copy_needed   = r_out_copy;
    assign o_rsp.page_released = r_out_rel;
    assign o_rsp.free_pages    = r_out_free;

    // The stack never holds more than the managed page count.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(PAGES))
        else $error("free stack depth beyond page count");

    // An accepted request always goes straight to execute.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    // A response appears only from execute or from the posting state.
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EXEC || $past(r_state) == S_POST))
        else $error("response raised outside execute or post");

    // A response is never overwritten while it waits for the sink.
    a_rsp_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_out_valid) |-> o_rsp.ready)
        else $error("pending response overwritten");

endmodule

### dv/cow_page_frame_allocator_test.sv
module cow_page_frame_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cpfa_pkg::*;

    localparam logic [63:0] ADDR_MASK     = 64'h00FF_FFFF_FFFF_FFFF;
    localparam logic [63:0] PAGE_SPAN     = 64'd1 << PAGE_SHIFT;
    localparam int          REF_MAX       = (1 << REF_BITS) - 1;
    localparam int          RUN_LIMIT     = 1_500_000;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          HOLDOFF_LEN   = 300;

    // Command codes that the block must ignore.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = CMD_SHARE + 3'd1;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = CMD_SHARE + 3'd2;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = CMD_SHARE + 3'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] result_addr;
        logic [STAT_W-1:0] status;
        logic              copy_needed;
        logic              page_released;
        logic [FREE_W-1:0] free_pages;
    } t_page_reply;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        t_page_reply       reply;
    } t_directed_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    cpfa_req_if req_ch ();
    cpfa_rsp_if rsp_ch ();

    cow_page_frame_allocator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the allocator state and its configuration.
    bit [IDX_W-1:0]    shadow_stack [PAGES];
    bit [REF_BITS-1:0] shadow_refs  [PAGES];
    int unsigned       shadow_depth = 0;
    logic [63:0]       cfg_base       = 64'(BASE_RST);
    logic [63:0]       cfg_first_free = 64'(FIRST_FREE_RST);
    logic [63:0]       cfg_top        = 64'(TOP_RST);

    t_page_reply replies_due [$];
    logic [63:0] live_pages [$];
    int unsigned error_count = 0;
    int unsigned burst_left  = 0;
    int unsigned cycle_count = 0;

    // Directed requests. Rows with typed set carry their reply; the rest use the predictor.
    t_directed_row directed_rows [23] = '{
        '{CMD_ALLOC,   56'h0,              1'b1, {56'h0, ST_NO_FREE, 1'b0, 1'b0, 16'd0}},
        '{CMD_FREE,    56'h8000_0000,      1'b1, {56'h0, ST_DOUBLE_FREE, 1'b0, 1'b0, 16'd0}},
        '{CMD_FREE,    56'h8000_0001,      1'b1, {56'h0, ST_BAD_ADDR, 1'b0, 1'b0, 16'd0}},
        '{CMD_FREE,    56'h8800_0000,      1'b1, {56'h0, ST_BAD_ADDR, 1'b0, 1'b0, 16'd0}},
        '{CMD_FREE,    56'h7FFF_F000,      1'b1, {56'h0, ST_BAD_ADDR, 1'b0, 1'b0, 16'd0}},
        '{CMD_SHARE,   56'h8000_0000,      1'b1, {56'h0, ST_BAD_ADDR, 1'b0, 1'b0, 16'd0}},
        '{CMD_COW,     56'h8000_0000,      1'b1,
          {56'h8000_0000, ST_OK, 1'b0, 1'b0, 16'd0}},
        '{CMD_SPARE_A, 56'hFF_FFFF_FFFF_FFFF, 1'b1, {56'h0, ST_OK, 1'b0, 1'b0, 16'd0}},
        '{CMD_SPARE_B, 56'h0,              1'b1, {56'h0, ST_OK, 1'b0, 1'b0, 16'd0}},
        '{CMD_SPARE_C, 56'hAA_AAAA_AAAA_AAAA, 1'b1, {56'h0, ST_OK, 1'b0, 1'b0, 16'd0}},
        '{CMD_INIT,    56'h0,              1'b1, {56'h0, ST_OK, 1'b0, 1'b0, 16'd32768}},
        '{CMD_ALLOC,   56'h0,              1'b1,
          {56'h87FF_F000, ST_OK, 1'b0, 1'b0, 16'd32767}},
        '{CMD_ALLOC,   56'h0,              1'b1,
          {56'h87FF_E000, ST_OK, 1'b0, 1'b0, 16'd32766}},
        '{CMD_SHARE,   56'h87FF_F000,      1'b1,
          {56'h87FF_F000, ST_OK, 1'b0, 1'b0, 16'd32766}},
        '{CMD_COW,     56'h87FF_F000,      1'b0, '0},
        '{CMD_COW,     56'h87FF_F000,      1'b1,
          {56'h87FF_F000, ST_OK, 1'b0, 1'b0, 16'd32765}},
        '{CMD_FREE,    56'h87FF_E000,      1'b1, {56'h0, ST_OK, 1'b0, 1'b1, 16'd32766}},
        '{CMD_FREE,    56'h87FF_E000,      1'b1,
          {56'h0, ST_DOUBLE_FREE, 1'b0, 1'b0, 16'd32766}},
        '{CMD_FREE,    56'h8000_0000,      1'b1,
          {56'h0, ST_DOUBLE_FREE, 1'b0, 1'b0, 16'd32766}},
        '{CMD_SHARE,   56'hFF_FFFF_FFFF_FFFF, 1'b1,
          {56'h0, ST_BAD_ADDR, 1'b0, 1'b0, 16'd32766}},
        '{CMD_FREE,    56'h87FF_F000,      1'b1, {56'h0, ST_OK, 1'b0, 1'b1, 16'd32767}},
        '{CMD_COW,     56'h87FF_D000,      1'b0, '0},
        '{CMD_ALLOC,   56'h0,              1'b0, '0}
    };

    // Maps an address to its page index; fails on any address the block must reject.
    function automatic bit page_index_of(input logic [63:0] a, output int unsigned idx);
        logic [63:0] off;
        idx = 0;
        if (a[PAGE_SHIFT-1:0] != '0 || a < cfg_first_free || a >= cfg_top || a < cfg_base)
            return 1'b0;
        off = (a - cfg_base) >> PAGE_SHIFT;
        if (off >= PAGES)
            return 1'b0;
        idx = off[31:0];
        return 1'b1;
    endfunction

    // Applies one request to the shadow state and returns the reply it must produce.
    function automatic t_page_reply allocator_outcome(input logic [CMD_W-1:0] cmd,
                                                      input logic [ADDR_W-1:0] addr_in);
        t_page_reply r;
        logic [63:0] a;
        logic [63:0] start;
        logic [63:0] p;
        int unsigned idx;
        int unsigned nidx;
        r = '0;
        a = 64'(addr_in);
        case (cmd)
            CMD_INIT: begin
                // Every page from the rounded first free address up to the top, lowest first.
                start = (cfg_first_free + PAGE_SPAN - 1) & ~(PAGE_SPAN - 1);
                shadow_depth = 0;
                for (int i = 0; i < PAGES; i++) begin
                    shadow_refs[i] = '0;
                    p = cfg_base + (64'(i) << PAGE_SHIFT);
                    if (p >= start && p + PAGE_SPAN <= cfg_top && shadow_depth < PAGES) begin
                        shadow_stack[shadow_depth] = IDX_W'(i);
                        shadow_depth++;
                    end
                end
            end
            CMD_ALLOC: begin
                if (shadow_depth == 0) begin
                    r.status = ST_NO_FREE;
                end else begin
                    shadow_depth--;
                    nidx = 32'(shadow_stack[shadow_depth]);
                    shadow_refs[nidx] = REF_BITS'(1);
                    r.result_addr = ADDR_W'((cfg_base + (64'(nidx) << PAGE_SHIFT)) & ADDR_MASK);
                end
            end
            CMD_FREE: begin
                if (!page_index_of(a, idx)) begin
                    r.status = ST_BAD_ADDR;
                end else if (shadow_refs[idx] == 0) begin
                    r.status = ST_DOUBLE_FREE;
                end else begin
                    shadow_refs[idx]--;
                    // A push onto a full stack is dropped.
                    if (shadow_refs[idx] == 0 && shadow_depth < PAGES) begin
                        shadow_stack[shadow_depth] = IDX_W'(idx);
                        shadow_depth++;
                        r.page_released = 1'b1;
                    end
                end
            end
            CMD_COW: begin
                if (!page_index_of(a, idx)) begin
                    r.status = ST_BAD_ADDR;
                end else if (shadow_refs[idx] <= 1) begin
                    r.result_addr = addr_in;
                end else if (shadow_depth == 0) begin
                    r.status = ST_NO_MEM;
                end else begin
                    shadow_depth--;
                    nidx = 32'(shadow_stack[shadow_depth]);
                    shadow_refs[nidx] = REF_BITS'(1);
                    shadow_refs[idx]--;
                    r.result_addr = ADDR_W'((cfg_base + (64'(nidx) << PAGE_SHIFT)) & ADDR_MASK);
                    r.copy_needed = 1'b1;
                end
            end
            CMD_SHARE: begin
                // A page with no references is free and cannot be shared.
                if (!page_index_of(a, idx) || shadow_refs[idx] == 0) begin
                    r.status = ST_BAD_ADDR;
                end else begin
                    if (shadow_refs[idx] < REF_MAX)
                        shadow_refs[idx]++;
                    r.result_addr = addr_in;
                end
            end
            default: ;
        endcase
        r.free_pages = (shadow_depth > 32'hFFFF) ? '1 : FREE_W'(shadow_depth);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Addresses off the well-formed path: unaligned, out of range, free pages, extremes.
    function automatic logic [ADDR_W-1:0] stray_address();
        logic [63:0] a;
        logic [63:0] aligned_base;
        logic [63:0] start;
        aligned_base = cfg_base & ~(PAGE_SPAN - 1);
        start = (cfg_first_free + PAGE_SPAN - 1) & ~(PAGE_SPAN - 1);
        case ($urandom_range(0, 7))
            0: a = {$urandom, $urandom};
            1: a = aligned_base + (64'($urandom_range(0, 40)) << PAGE_SHIFT);
            2: a = (live_pages.size() != 0 ? live_pages[0] : start)
                   + 64'($urandom_range(1, (1 << PAGE_SHIFT) - 1));
            3: a = (cfg_top & ~(PAGE_SPAN - 1)) - PAGE_SPAN * 64'($urandom_range(0, 1));
            4: a = start - PAGE_SPAN;
            5: a = aligned_base + (64'($urandom_range(PAGES - 1, PAGES + 1)) << PAGE_SHIFT);
            6: a = $urandom_range(0, 1) ? ADDR_MASK : 64'd0;
            default: a = start + (64'($urandom_range(0, 20)) << PAGE_SHIFT);
        endcase
        return ADDR_W'(a & ADDR_MASK);
    endfunction

    // Mostly pages that are in use, so that the counts move.
    function automatic logic [ADDR_W-1:0] target_address();
        if (live_pages.size() != 0 && $urandom_range(0, 9) < 8)
            return ADDR_W'(live_pages[$urandom_range(0, live_pages.size() - 1)]);
        return stray_address();
    endfunction

    // Offers one request, waits for its transfer, records the reply it must cause,
    // then idles between bursts.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                                input bit typed, input t_page_reply typed_reply,
                                output t_page_reply reply);
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= cmd;
        req_ch.addr  <= addr;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        reply = allocator_outcome(cmd, addr);
        replies_due.push_back(typed ? typed_reply : reply);

        // Track the pages handed out, for targeting later requests.
        case (cmd)
            CMD_INIT: live_pages.delete();
            CMD_ALLOC: if (reply.status == ST_OK) live_pages.push_back(64'(reply.result_addr));
            CMD_COW: if (reply.copy_needed) live_pages.push_back(64'(reply.result_addr));
            CMD_FREE: begin
                if (reply.page_released) begin
                    for (int k = 0; k < live_pages.size(); k++) begin
                        if (live_pages[k] == 64'(addr)) begin
                            live_pages.delete(k);
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_register(input logic [REG_IDX_W-1:0] reg_idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_BASE:       cfg_base       = value & ADDR_MASK;
            REG_FIRST_FREE: cfg_first_free = value & ADDR_MASK;
            REG_TOP:        cfg_top        = value & ADDR_MASK;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // One configuration: wait for the block to go idle, reprogram it, init, then random traffic.
    task automatic run_phase(input logic [63:0] base_value, input logic [63:0] first_free_value,
                             input logic [63:0] top_value, input int items,
                             input bit reinit, input bit share_burst);
        t_page_reply got;
        logic [ADDR_W-1:0] hot_page;
        logic [ADDR_W-1:0] a;
        logic [CMD_W-1:0]  cmd;
        int roll;
        req_ch.valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        write_register(REG_BASE, base_value);
        write_register(REG_FIRST_FREE, first_free_value);
        write_register(REG_TOP, top_value);
        send_request(CMD_INIT, stray_address(), 1'b0, '0, got);

        // Drive one page's count into saturation and back down a little.
        if (share_burst) begin
            send_request(CMD_ALLOC, '0, 1'b0, '0, got);
            hot_page = got.result_addr;
            repeat (REF_MAX + 3) send_request(CMD_SHARE, hot_page, 1'b0, '0, got);
            repeat (3) send_request(CMD_FREE, hot_page, 1'b0, '0, got);
        end

        for (int n = 0; n < items; n++) begin
            roll = $urandom_range(0, 99);
            if (reinit && n == items / 2) begin
                cmd = CMD_INIT;
                a = stray_address();
            end else if (roll < 30) begin
                cmd = CMD_ALLOC;
                a = ADDR_W'({$urandom, $urandom});
            end else if (roll < 55) begin
                cmd = CMD_FREE;
                a = target_address();
            end else if (roll < 70) begin
                cmd = CMD_COW;
                a = target_address();
            end else if (roll < 90) begin
                cmd = CMD_SHARE;
                a = target_address();
            end else begin
                cmd = CMD_W'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
                a = stray_address();
            end
            send_request(cmd, a, 1'b0, '0, got);
        end
    endtask

    // Response side: stall patterns of its own, with two long hold-offs.
    initial begin
        int unsigned reply_count;
        int unsigned holdoff;
        int unsigned mode_left;
        int unsigned mode;
        reply_count = 0;
        holdoff = 0;
        mode_left = 0;
        mode = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                reply_count++;
                if (reply_count == 150 || reply_count == 600)
                    holdoff = HOLDOFF_LEN;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(8, 60);
            end
            mode_left--;
            if (holdoff != 0) begin
                holdoff--;
                rsp_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Every response transfer is matched against the oldest awaited reply.
    always @(posedge i_clk) begin
        t_page_reply want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (replies_due.size() == 0) begin
                $error("response transfer with no request outstanding");
                error_count++;
            end else begin
                want = replies_due.pop_front();
                check_field("result_addr", 64'(want.result_addr), 64'(rsp_ch.result_addr));
                check_field("status", 64'(want.status), 64'(rsp_ch.status));
                check_field("copy_needed", 64'(want.copy_needed), 64'(rsp_ch.copy_needed));
                check_field("page_released", 64'(want.page_released),
                            64'(rsp_ch.page_released));
                check_field("free_pages", 64'(want.free_pages), 64'(rsp_ch.free_pages));
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("cow_page_frame_allocator test failed");
            $finish;
        end
    end

    initial begin
        t_page_reply got;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd   = CMD_INIT;
        req_ch.addr  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, at the reset configuration.
        foreach (directed_rows[i])
            send_request(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].typed,
                         directed_rows[i].reply, got);

        // Eight-page pool with an unaligned first free address and a re-init midway.
        run_phase(64'h8000_0000, 64'h8000_3005, 64'h8000_C000, 170, 1'b1, 1'b0);
        // Whole address space: every page index in use, index limit reachable.
        run_phase(64'h0, 64'h0, ADDR_MASK, 100, 1'b0, 1'b0);
        // Nothing to manage: base at the top, top at zero.
        run_phase(ADDR_MASK, ADDR_MASK, 64'h0, 30, 1'b0, 1'b0);
        // Pool pressed against the end of the address space.
        run_phase(64'h00FF_FFFF_FFFF_0000, 64'h00FF_FFFF_FFFF_0000, ADDR_MASK, 120, 1'b0, 1'b0);
        // Unaligned base, so handed-out pages are unaligned.
        run_phase(64'h1234_5800, 64'h1234_5800, 64'h1235_0000, 80, 1'b0, 1'b0);
        // Three pages and a saturated count.
        run_phase(64'h4000_0000, 64'h4000_0000, 64'h4000_3000, 40, 1'b0, 1'b1);

        req_ch.valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("cow_page_frame_allocator test passed");
        else
            $display("cow_page_frame_allocator test failed");
        $finish;
    end

endmodule
